// ----- design/tlsrd_pkg.sv -----
// shared types and constants for the tls record deframer
package tlsrd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned SKIP_W       = 10;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  localparam logic [SKIP_W-1:0]  SKIP_RESET   = SKIP_W'(102);
  localparam logic [COUNT_W-1:0] HEADER_BYTES = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] LEN_HI_POS   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] LEN_LO_POS   = COUNT_W'(4);

  // register index as seen on paddr[2]
  localparam logic REG_HANDSHAKE_SKIP = 1'b0;

  // parsing phase, one-hot
  typedef enum logic [2:0] {
    PH_SKIP    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              record_last;
  } result_t;

endpackage

// ----- design/tls_record_deframer.sv -----
// tls record deframer top level: skip handshake, parse headers, emit payload bytes
// a payload byte is registered into the output register, or into the skid stage while a result is stalled
// throughput: one stream byte per cycle while the skid stage is empty; the output register plus a one-entry skid
//   stage keep the input open for one more payload byte while a result is stalled
// reset: synchronous active-low rst_n returns to the skip phase with zero counts,
//   empties the output stages and sets handshake_skip_bytes back to 102
module tls_record_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tlsrd_pkg::BYTE_W-1:0]        in_stream_byte,
  // result stream
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tlsrd_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic                                out_record_last,
  // apb configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlsrd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tlsrd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tlsrd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import tlsrd_pkg::*;

  logic [SKIP_W-1:0]  skip_r;
  phase_t             phase_r, phase_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] len_r, len_nxt;
  logic [COUNT_W-1:0] hdr_cnt, hdr_inc, cnt_inc;
  logic               hdr_go;
  logic               res_valid;
  result_t            res;
  result_t            out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               in_fire, out_fire;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HANDSHAKE_SKIP) ? APB_DATA_W'(skip_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HANDSHAKE_SKIP)) begin
      skip_r <= pwdata[SKIP_W-1:0];
    end
  end

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign cnt_inc = cnt_r + COUNT_W'(1);

  // next parser state and result for the byte on the input
  always_comb begin
    phase_nxt        = phase_r;
    cnt_nxt          = cnt_r;
    len_nxt          = len_r;
    hdr_go           = 1'b0;
    hdr_cnt          = cnt_r;
    res_valid        = 1'b0;
    res.payload_byte = in_stream_byte;
    res.record_last  = 1'b0;
    unique case (phase_r)
      PH_SKIP: begin
        if (cnt_r < COUNT_W'(skip_r)) begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= COUNT_W'(skip_r)) begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end else begin
          // skip already done, this byte opens the first header
          hdr_go  = 1'b1;
          hdr_cnt = '0;
        end
      end
      PH_PAYLOAD: begin
        res_valid       = 1'b1;
        res.record_last = (cnt_inc >= len_r);
        cnt_nxt         = cnt_inc;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = '0;
        end
      end
      PH_HEADER: hdr_go = 1'b1;
      default:   hdr_go = 1'b1;
    endcase

    // header byte handling, length in bytes 3 and 4
    hdr_inc = hdr_cnt + COUNT_W'(1);
    if (hdr_go) begin
      phase_nxt = PH_HEADER;
      if (hdr_cnt == LEN_HI_POS) begin
        len_nxt = {in_stream_byte, len_r[BYTE_W-1:0]};
      end else if (hdr_cnt == LEN_LO_POS) begin
        len_nxt = {len_r[COUNT_W-1:BYTE_W], in_stream_byte};
      end
      cnt_nxt = hdr_inc;
      if (hdr_inc >= HEADER_BYTES) begin
        cnt_nxt   = '0;
        phase_nxt = (len_nxt == '0) ? PH_HEADER : PH_PAYLOAD;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      cnt_r   <= '0;
      len_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_record_last  = out_r.record_last;

endmodule

// ----- design/tlsrd_checker.sv -----
// port-level assertions for the tls record deframer, with bind
module tlsrd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tlsrd_pkg::BYTE_W-1:0]    out_payload_byte,
  input logic                            out_record_last
);
  import tlsrd_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_record_last))
    else $error("stalled result changed");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // a new result only follows an input transaction
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transaction");

  // input closes only while both output stages are full
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind tls_record_deframer tlsrd_checker u_tlsrd_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// testbench for the tls record deframer: directed stimulus table, then random record streams
module tb;
  import tlsrd_pkg::*;

  // directed table layout
  typedef enum logic [1:0] {ROW_BYTE, ROW_SKIP_WRITE} row_kind_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_RESULT, CHK_PREDICT} row_check_t;
  typedef struct packed {
    row_kind_t        kind;
    logic [SKIP_W-1:0] value;
    row_check_t       check;
    logic [BYTE_W-1:0] exp_byte;
    logic             exp_last;
  } stim_row_t;

  localparam int N_ROWS = 25;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // two bytes dropped under the reset skip count
    '{ROW_BYTE,       10'h000, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h0ff, CHK_NONE,    8'h00, 1'b0},
    // widest skip count, applied while still skipping
    '{ROW_SKIP_WRITE, 10'd1023, CHK_NONE,   8'h00, 1'b0},
    '{ROW_BYTE,       10'h05a, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h0a5, CHK_NONE,    8'h00, 1'b0},
    // skip count of zero, already below the bytes taken: next byte opens a header
    '{ROW_SKIP_WRITE, 10'd0,    CHK_NONE,   8'h00, 1'b0},
    // empty record
    '{ROW_BYTE,       10'h017, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h003, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h003, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h000, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h000, CHK_NONE,    8'h00, 1'b0},
    // one byte record
    '{ROW_BYTE,       10'h017, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h003, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h003, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h000, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h001, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h0ff, CHK_RESULT,  8'hff, 1'b1},
    // three byte record, header type and version all ones
    '{ROW_BYTE,       10'h0ff, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h0ff, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h0ff, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h000, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h003, CHK_NONE,    8'h00, 1'b0},
    '{ROW_BYTE,       10'h000, CHK_RESULT,  8'h00, 1'b0},
    '{ROW_BYTE,       10'h080, CHK_PREDICT, 8'h00, 1'b0},
    '{ROW_BYTE,       10'h07f, CHK_RESULT,  8'h7f, 1'b1}
  };

  localparam logic [APB_ADDR_W-1:0] SKIP_ADDR = {REG_HANDSHAKE_SKIP, 2'b00};
  localparam logic [SKIP_W-1:0] PHASE_SKIPS [4] = '{10'd1023, 10'd0, 10'h155, 10'h2aa};
  localparam int PHASE_BYTES = 330;
  localparam int HOLD_CYCLES = 80;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_stream_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BYTE_W-1:0]     out_payload_byte;
  logic                  out_record_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tls_record_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_stream_byte   (in_stream_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_record_last  (out_record_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // deframer state as predicted
  phase_t             rx_phase;
  logic [COUNT_W-1:0] rx_count;
  logic [COUNT_W-1:0] rx_len;
  logic [SKIP_W-1:0]  skip_cfg;

  result_t expected_payload[$];
  int fail_count = 0;
  int bytes_sent = 0;
  int records_sent = 0;
  int results_seen = 0;
  int skip_writes = 0;
  int longest_record = 0;
  int burst_left = 0;
  bit long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  initial begin
    #(80_000_000);
    $display("simulation failed");
    $finish;
  end

  // predict one stream byte; returns 1 when a payload byte comes out
  function automatic bit deframe_step(input logic [BYTE_W-1:0] b, output result_t res);
    res = '0;
    if (rx_phase == PH_SKIP) begin
      if (rx_count < COUNT_W'(skip_cfg)) begin
        rx_count = rx_count + 1'b1;
        if (rx_count >= COUNT_W'(skip_cfg)) begin
          rx_phase = PH_HEADER;
          rx_count = '0;
        end
        return 1'b0;
      end
      // skip already done: this byte opens the first header
      rx_phase = PH_HEADER;
      rx_count = '0;
    end
    if (rx_phase == PH_PAYLOAD) begin
      rx_count = rx_count + 1'b1;
      res.payload_byte = b;
      res.record_last = (rx_count >= rx_len);
      if (res.record_last) begin
        rx_phase = PH_HEADER;
        rx_count = '0;
      end
      return 1'b1;
    end
    // header: bytes 3 and 4 carry the big-endian length
    if (rx_count == LEN_HI_POS) rx_len[15:8] = b;
    else if (rx_count == LEN_LO_POS) rx_len[7:0] = b;
    rx_count = rx_count + 1'b1;
    if (rx_count >= HEADER_BYTES) begin
      rx_count = '0;
      rx_phase = (rx_len == '0) ? PH_HEADER : PH_PAYLOAD;
    end
    return 1'b0;
  endfunction

  // offer one byte in bursts with random gaps, return once accepted
  task automatic offer_byte(input logic [BYTE_W-1:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      in_stream_byte <= BYTE_W'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    result_t res;
    offer_byte(b);
    if (deframe_step(b, res)) expected_payload.push_back(res);
  endtask

  // header with random type and version, then random payload
  task automatic send_record(input logic [COUNT_W-1:0] len);
    push_byte(BYTE_W'($urandom));
    push_byte(BYTE_W'($urandom));
    push_byte(BYTE_W'($urandom));
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    for (int k = 0; k < int'(len); k++) push_byte(BYTE_W'($urandom));
    records_sent++;
    if (int'(len) > longest_record) longest_record = int'(len);
  endtask

  function automatic logic [COUNT_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 80) return COUNT_W'($urandom_range(1, 16));
    if (r < 96) return COUNT_W'($urandom_range(17, 80));
    if (r < 99) return COUNT_W'($urandom_range(81, 300));
    return COUNT_W'($urandom_range(256, 511));
  endfunction

  // stop sending until every expected payload byte has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_payload.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_skip(input logic [SKIP_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SKIP_ADDR;
    pwdata <= {22'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    skip_cfg = v;
    skip_writes++;
  endtask

  // receiver: ready and stall runs of random length, plus requested long holds
  initial begin
    int run_left;
    int hold_left;
    bit run_ready;
    run_left = 0;
    hold_left = 0;
    run_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          if (run_ready)
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 20);
          else
            run_left = $urandom_range(1, 6);
        end
        run_left--;
        out_ready <= run_ready;
      end
    end
  end

  // result check against the oldest expected payload byte
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_payload.size() == 0) begin
        $error("unexpected result transaction: payload_byte %0h record_last %0b",
               out_payload_byte, out_record_last);
        fail_count++;
      end else begin
        want = expected_payload.pop_front();
        if (out_payload_byte !== want.payload_byte) begin
          $error("payload_byte mismatch: expected %0h actual %0h",
                 want.payload_byte, out_payload_byte);
          fail_count++;
        end
        if (out_record_last !== want.record_last) begin
          $error("record_last mismatch: expected %0b actual %0b",
                 want.record_last, out_record_last);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    result_t   res;
    bit        emits;
    int        phase_start;
    int        recs;
    int        guard;

    rx_phase = PH_SKIP;
    rx_count = '0;
    rx_len = '0;
    skip_cfg = SKIP_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_ROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_SKIP_WRITE) begin
        wait_idle();
        write_skip(row.value);
      end else begin
        offer_byte(row.value[BYTE_W-1:0]);
        emits = deframe_step(row.value[BYTE_W-1:0], res);
        case (row.check)
          CHK_RESULT: begin
            res.payload_byte = row.exp_byte;
            res.record_last = row.exp_last;
            expected_payload.push_back(res);
          end
          CHK_PREDICT: begin
            if (emits) expected_payload.push_back(res);
          end
          default: ;
        endcase
      end
    end

    // random record streams; skip writes after the skip phase are stored only
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_skip(PHASE_SKIPS[ph]);
      phase_start = bytes_sent;
      recs = 0;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (ph == 1 && recs % 12 == 0) long_hold_req = 1'b1;
        if (ph == 2 && recs == 6) wait_idle();
        send_record(pick_length());
        recs++;
      end
    end

    // one record whose length has only the high byte set
    send_record(COUNT_W'(16'h0100));

    // drain
    in_valid <= 1'b0;
    guard = 0;
    while (expected_payload.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_payload.size() != 0) begin
      $error("%0d expected payload bytes never came out", expected_payload.size());
      fail_count++;
    end

    $display("covered %0d stream bytes in %0d records, %0d payload bytes checked",
             bytes_sent, records_sent, results_seen);
    $display("skip count written %0d times, longest record %0d bytes",
             skip_writes, longest_record);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tlsrd_pkg.sv
design/tls_record_deframer.sv
design/tlsrd_checker.sv
tb/tb.sv
